### hdl/fe_grad_pkg.sv
package fe_grad_pkg;

  typedef logic signed [63:0] acc_t;

  localparam acc_t AccMax = {1'b0, {63{1'b1}}};
  localparam acc_t AccMin = {1'b1, {63{1'b0}}};

  localparam logic FuncGeom = 1'b0;
  localparam logic KindDet  = 1'b0;
  localparam logic KindGrad = 1'b1;

  localparam logic [1:0] DimTwo   = 2'd2;
  localparam logic [1:0] DimReset = 2'd3;

  typedef enum logic [2:0] {
    SrcCoord, SrcDeriv, SrcJac, SrcCof, SrcSum, SrcRecip
  } src_e;

  typedef enum logic [1:0] {
    ShNone, ShF, Sh2F, Sh3F
  } sh_e;

  typedef enum logic [2:0] {
    WbNone, WbJacAcc, WbTmp, WbCof, WbDet, WbSum, WbGrad
  } wb_e;

  typedef struct packed {
    logic       mul_start;
    src_e       a_src;
    logic [3:0] a_idx;
    src_e       b_src;
    logic [3:0] b_idx;
    sh_e        sh;
    wb_e        wb;
    logic [3:0] wb_idx;
    logic       cof2d;
    logic       clr_det;
    logic       clr_sum;
    logic       clr_grad;
    logic       div_start;
    logic       finish;
    logic       emit;
    logic       emit_kind;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic func;
    logic last;
    logic dim2;
    logic mul_done;
    logic mul_busy;
    logic div_done;
    logic div_busy;
    logic det_bad;
    logic out_free;
  } sts_t;

  function automatic acc_t sat_add(acc_t a, acc_t b);
    acc_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? AccMin : AccMax;
    return s;
  endfunction

  function automatic acc_t sat_sub(acc_t a, acc_t b);
    acc_t s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) return a[63] ? AccMin : AccMax;
    return s;
  endfunction

  function automatic logic [3:0] idx9(logic [1:0] r, logic [1:0] k);
    return {r, 2'b00} - {2'b00, r} + {2'b00, k};
  endfunction

  function automatic logic [1:0] inc3(logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

endpackage

### hdl/fe_grad_in_if.sv
interface fe_grad_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic                          start_element;
  logic signed [VALUE_WIDTH-1:0] coord_x;
  logic signed [VALUE_WIDTH-1:0] coord_y;
  logic signed [VALUE_WIDTH-1:0] coord_z;
  logic signed [VALUE_WIDTH-1:0] deriv_0;
  logic signed [VALUE_WIDTH-1:0] deriv_1;
  logic signed [VALUE_WIDTH-1:0] deriv_2;
  logic                          last_node;

  modport source (
    output valid, func, start_element, coord_x, coord_y, coord_z,
    output deriv_0, deriv_1, deriv_2, last_node,
    input  ready
  );
  modport sink (
    input  valid, func, start_element, coord_x, coord_y, coord_z,
    input  deriv_0, deriv_1, deriv_2, last_node,
    output ready
  );
endinterface

### hdl/fe_grad_out_if.sv
interface fe_grad_out_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [63:0]            det_j;
  logic                          bad_point;
  logic                          element_bad;
  logic signed [VALUE_WIDTH-1:0] grad_x;
  logic signed [VALUE_WIDTH-1:0] grad_y;
  logic signed [VALUE_WIDTH-1:0] grad_z;
  logic                          last;

  modport source (
    output valid, kind, det_j, bad_point, element_bad, grad_x, grad_y, grad_z, last,
    input  ready
  );
  modport sink (
    input  valid, kind, det_j, bad_point, element_bad, grad_x, grad_y, grad_z, last,
    output ready
  );
endinterface

### hdl/fe_grad_mul.sv
module fe_grad_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  fe_grad_pkg::acc_t    a_i,
  input  fe_grad_pkg::acc_t    b_i,
  input  fe_grad_pkg::sh_e     sh_i,
  output logic                 busy_o,
  output logic                 done_o,
  output fe_grad_pkg::acc_t    res_o
);

  localparam int unsigned ShOne   = FRAC_BITS;
  localparam int unsigned ShTwo   = 2 * FRAC_BITS;
  localparam int unsigned ShThree = 3 * FRAC_BITS;

  typedef enum logic [1:0] {MIdle, MPart, MShift, MSat} mstate_e;

  mstate_e           state_q;
  logic [1:0]        cnt_q;
  logic              neg_q;
  logic [63:0]       ua_q, ub_q;
  logic [127:0]      prod_q;
  fe_grad_pkg::sh_e  sh_q;
  logic [127:0]      q_q;
  logic              lost_q;
  logic              done_q;
  fe_grad_pkg::acc_t res_q;

  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_pos;
  int unsigned  sha;
  logic [127:0] q_d, mask;
  logic [127:0] qi;
  fe_grad_pkg::acc_t res_d;

  assign a_half = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
  assign b_half = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
  assign pp     = a_half * b_half;

  always_comb begin
    unique case (cnt_q)
      2'd0:    pp_pos = {64'd0, pp};
      2'd3:    pp_pos = {pp, 64'd0};
      default: pp_pos = {32'd0, pp, 32'd0};
    endcase
  end

  always_comb begin
    unique case (sh_q)
      fe_grad_pkg::ShNone: sha = 0;
      fe_grad_pkg::ShF:    sha = ShOne;
      fe_grad_pkg::Sh2F:   sha = ShTwo;
      default:             sha = ShThree;
    endcase
    q_d  = prod_q >> sha;
    mask = (128'd1 << sha) - 128'd1;
  end

  always_comb begin
    qi = q_q + {127'd0, neg_q & lost_q};
    if (neg_q) begin
      res_d = (|qi[127:63]) ? fe_grad_pkg::AccMin : -$signed(qi[63:0]);
    end else begin
      res_d = (|qi[127:63]) ? fe_grad_pkg::AccMax : $signed(qi[63:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MIdle;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      ua_q    <= '0;
      ub_q    <= '0;
      prod_q  <= '0;
      sh_q    <= fe_grad_pkg::ShNone;
      q_q     <= '0;
      lost_q  <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        MIdle: begin
          if (start_i) begin
            neg_q   <= a_i[63] ^ b_i[63];
            ua_q    <= a_i[63] ? (~a_i + 64'd1) : a_i;
            ub_q    <= b_i[63] ? (~b_i + 64'd1) : b_i;
            sh_q    <= sh_i;
            prod_q  <= '0;
            cnt_q   <= '0;
            state_q <= MPart;
          end
        end
        MPart: begin
          prod_q <= prod_q + pp_pos;
          cnt_q  <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_q <= MShift;
        end
        MShift: begin
          q_q     <= q_d;
          lost_q  <= |(prod_q & mask);
          state_q <= MSat;
        end
        default: begin
          res_q   <= res_d;
          done_q  <= 1'b1;
          state_q <= MIdle;
        end
      endcase
    end
  end

  assign busy_o = (state_q != MIdle);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/fe_grad_div.sv
module fe_grad_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  fe_grad_pkg::acc_t d_i,
  output logic              busy_o,
  output logic              done_o,
  output fe_grad_pkg::acc_t res_o
);

  localparam int unsigned Sh  = 4 * FRAC_BITS;
  localparam int unsigned ShW = $clog2(Sh + 1);
  localparam logic [ShW-1:0] ShTop = ShW'(Sh);
  localparam logic [ShW-1:0] BitHi = ShW'(63);

  logic           busy_q, done_q, sat_q;
  logic [ShW-1:0] b_q;
  logic [63:0]    r_q, d_q, q_q;

  logic [64:0] rs, diff;
  logic        ge;
  logic [63:0] r_d;

  assign rs   = {r_q, (b_q == ShTop)};
  assign ge   = rs >= {1'b0, d_q};
  assign diff = rs - {1'b0, d_q};
  assign r_d  = ge ? diff[63:0] : rs[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      b_q    <= '0;
      r_q    <= '0;
      d_q    <= '0;
      q_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          busy_q <= 1'b1;
          sat_q  <= 1'b0;
          b_q    <= ShTop;
          r_q    <= '0;
          q_q    <= '0;
          d_q    <= d_i;
        end
      end else begin
        r_q <= r_d;
        q_q <= {q_q[62:0], ge};
        if (ge && b_q >= BitHi) sat_q <= 1'b1;
        if (b_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          b_q <= b_q - 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = sat_q ? fe_grad_pkg::AccMax : $signed(q_q);

endmodule

### hdl/fe_grad_dp.sv
module fe_grad_dp #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_wdata_i,
  input  logic                 in_ready_i,
  input  fe_grad_pkg::cmd_t    cmd_i,
  output fe_grad_pkg::sts_t    sts_o,
  fe_grad_in_if.sink           in_i,
  fe_grad_out_if.source        out_o
);

  localparam fe_grad_pkg::acc_t VMax =
    {{(65 - VALUE_WIDTH){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
  localparam fe_grad_pkg::acc_t VMin = ~VMax;

  fe_grad_pkg::acc_t crd_q [3];
  fe_grad_pkg::acc_t drv_q [3];
  fe_grad_pkg::acc_t jac_q [9];
  fe_grad_pkg::acc_t cof_q [9];
  fe_grad_pkg::acc_t tmp_q, det_q, sum_q, recip_q;
  logic signed [VALUE_WIDTH-1:0] grad_q [3];
  logic       func_q, last_q, point_q, elem_q;
  logic [1:0] dim_q;

  logic                          o_valid_q, o_kind_q, o_bad_q, o_elem_q, o_last_q;
  logic signed [63:0]            o_det_q;
  logic signed [VALUE_WIDTH-1:0] o_grad_q [3];

  logic              accept, det_bad, out_free;
  fe_grad_pkg::acc_t op_a, op_b, mul_res, div_res;
  logic              mul_busy, mul_done, div_busy, div_done;

  function automatic fe_grad_pkg::acc_t pick(fe_grad_pkg::src_e s, logic [3:0] i);
    fe_grad_pkg::acc_t v;
    v = '0;
    unique case (s)
      fe_grad_pkg::SrcCoord: if (i[1:0] != 2'd3) v = crd_q[i[1:0]];
      fe_grad_pkg::SrcDeriv: if (i[1:0] != 2'd3) v = drv_q[i[1:0]];
      fe_grad_pkg::SrcJac:   if (i < 4'd9) v = jac_q[i];
      fe_grad_pkg::SrcCof:   if (i < 4'd9) v = cof_q[i];
      fe_grad_pkg::SrcSum:   v = sum_q;
      fe_grad_pkg::SrcRecip: v = recip_q;
      default:               v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] vsat(fe_grad_pkg::acc_t v);
    fe_grad_pkg::acc_t c;
    c = v;
    if (v > VMax) c = VMax;
    if (v < VMin) c = VMin;
    return c[VALUE_WIDTH-1:0];
  endfunction

  assign accept   = in_i.valid && in_ready_i;
  assign det_bad  = det_q[63] || (det_q == '0);
  assign out_free = !o_valid_q || out_o.ready;
  assign op_a     = pick(cmd_i.a_src, cmd_i.a_idx);
  assign op_b     = pick(cmd_i.b_src, cmd_i.b_idx);

  fe_grad_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i, .rst_ni,
    .start_i(cmd_i.mul_start),
    .a_i(op_a), .b_i(op_b), .sh_i(cmd_i.sh),
    .busy_o(mul_busy), .done_o(mul_done), .res_o(mul_res)
  );

  fe_grad_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start),
    .d_i(det_q),
    .busy_o(div_busy), .done_o(div_done), .res_o(div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        crd_q[i]    <= '0;
        drv_q[i]    <= '0;
        grad_q[i]   <= '0;
        o_grad_q[i] <= '0;
      end
      for (int i = 0; i < 9; i++) begin
        jac_q[i] <= '0;
        cof_q[i] <= '0;
      end
      tmp_q     <= '0;
      det_q     <= '0;
      sum_q     <= '0;
      recip_q   <= '0;
      func_q    <= 1'b0;
      last_q    <= 1'b0;
      point_q   <= 1'b0;
      elem_q    <= 1'b0;
      dim_q     <= fe_grad_pkg::DimReset;
      o_valid_q <= 1'b0;
      o_kind_q  <= fe_grad_pkg::KindDet;
      o_bad_q   <= 1'b0;
      o_elem_q  <= 1'b0;
      o_last_q  <= 1'b0;
      o_det_q   <= '0;
    end else begin
      if (cfg_we_i) dim_q <= cfg_wdata_i;

      if (accept) begin
        func_q   <= in_i.func;
        last_q   <= in_i.last_node;
        crd_q[0] <= fe_grad_pkg::acc_t'(in_i.coord_x);
        crd_q[1] <= fe_grad_pkg::acc_t'(in_i.coord_y);
        crd_q[2] <= fe_grad_pkg::acc_t'(in_i.coord_z);
        drv_q[0] <= fe_grad_pkg::acc_t'(in_i.deriv_0);
        drv_q[1] <= fe_grad_pkg::acc_t'(in_i.deriv_1);
        drv_q[2] <= fe_grad_pkg::acc_t'(in_i.deriv_2);
        if (in_i.start_element) elem_q <= 1'b0;
      end

      unique case (cmd_i.wb)
        fe_grad_pkg::WbJacAcc:
          jac_q[cmd_i.wb_idx] <= fe_grad_pkg::sat_add(jac_q[cmd_i.wb_idx], mul_res);
        fe_grad_pkg::WbTmp: tmp_q <= mul_res;
        fe_grad_pkg::WbCof: cof_q[cmd_i.wb_idx] <= fe_grad_pkg::sat_sub(tmp_q, mul_res);
        fe_grad_pkg::WbDet: det_q <= fe_grad_pkg::sat_add(det_q, mul_res);
        fe_grad_pkg::WbSum: sum_q <= fe_grad_pkg::sat_add(sum_q, mul_res);
        fe_grad_pkg::WbGrad: grad_q[cmd_i.wb_idx[1:0]] <= vsat(mul_res);
        default: ;
      endcase

      if (cmd_i.cof2d) begin
        for (int i = 0; i < 9; i++) cof_q[i] <= '0;
        cof_q[0] <= jac_q[4];
        cof_q[1] <= fe_grad_pkg::sat_sub('0, jac_q[3]);
        cof_q[3] <= fe_grad_pkg::sat_sub('0, jac_q[1]);
        cof_q[4] <= jac_q[0];
      end
      if (cmd_i.clr_det) det_q <= '0;
      if (cmd_i.clr_sum) sum_q <= '0;
      if (cmd_i.clr_grad) begin
        for (int i = 0; i < 3; i++) grad_q[i] <= '0;
      end

      if (cmd_i.finish) begin
        point_q <= det_bad;
        if (det_bad) elem_q <= 1'b1;
        recip_q <= det_bad ? '0 : div_res;
        for (int i = 0; i < 9; i++) jac_q[i] <= '0;
      end

      if (cmd_i.emit) begin
        o_valid_q <= 1'b1;
        o_kind_q  <= cmd_i.emit_kind;
        o_bad_q   <= point_q;
        o_elem_q  <= elem_q;
        if (cmd_i.emit_kind == fe_grad_pkg::KindDet) begin
          o_det_q  <= det_q;
          o_last_q <= 1'b0;
          for (int i = 0; i < 3; i++) o_grad_q[i] <= '0;
        end else begin
          o_det_q  <= '0;
          o_last_q <= last_q;
          for (int i = 0; i < 3; i++) o_grad_q[i] <= grad_q[i];
        end
      end else if (out_o.ready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  assign in_i.ready        = in_ready_i;
  assign out_o.valid       = o_valid_q;
  assign out_o.kind        = o_kind_q;
  assign out_o.det_j       = o_det_q;
  assign out_o.bad_point   = o_bad_q;
  assign out_o.element_bad = o_elem_q;
  assign out_o.grad_x      = o_grad_q[0];
  assign out_o.grad_y      = o_grad_q[1];
  assign out_o.grad_z      = o_grad_q[2];
  assign out_o.last        = o_last_q;

  always_comb begin
    sts_o          = '0;
    sts_o.in_valid = in_i.valid;
    sts_o.func     = func_q;
    sts_o.last     = last_q;
    sts_o.dim2     = (dim_q == fe_grad_pkg::DimTwo);
    sts_o.mul_done = mul_done;
    sts_o.mul_busy = mul_busy;
    sts_o.div_done = div_done;
    sts_o.div_busy = div_busy;
    sts_o.det_bad  = det_bad;
    sts_o.out_free = out_free;
  end

endmodule

### hdl/fe_grad_ctrl.sv
module fe_grad_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fe_grad_pkg::sts_t sts_i,
  output logic              in_ready_o,
  output fe_grad_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    SIdle, SDispatch, SMac, SMacW, SCofStart, SCofM1, SCofW1, SCofM2, SCofW2,
    SDetInit, SDetM, SDetW, SDetSettle, SDetChk, SDivW, SFinish, SEmit,
    SFldRow, SFldM, SFldW, SFldG, SFldGW
  } state_e;

  state_e            state_q;
  fe_grad_pkg::cmd_t cmd_q;
  logic [1:0]        r_q, k_q;
  logic              kind_q;
  logic [1:0]        nl, r1, r2, k1, k2;

  assign nl = sts_i.dim2 ? 2'd1 : 2'd2;
  assign r1 = fe_grad_pkg::inc3(r_q);
  assign r2 = fe_grad_pkg::inc3(r1);
  assign k1 = fe_grad_pkg::inc3(k_q);
  assign k2 = fe_grad_pkg::inc3(k1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cmd_q   <= '0;
      r_q     <= '0;
      k_q     <= '0;
      kind_q  <= fe_grad_pkg::KindDet;
    end else begin
      cmd_q <= '0;
      unique case (state_q)
        SIdle: if (sts_i.in_valid) state_q <= SDispatch;
        SDispatch: begin
          r_q <= '0;
          k_q <= '0;
          if (sts_i.func == fe_grad_pkg::FuncGeom) begin
            state_q <= SMac;
          end else begin
            cmd_q.clr_grad <= 1'b1;
            state_q        <= SFldRow;
          end
        end
        SMac: begin
          cmd_q.mul_start <= 1'b1;
          cmd_q.a_src     <= fe_grad_pkg::SrcCoord;
          cmd_q.a_idx     <= {2'b00, r_q};
          cmd_q.b_src     <= fe_grad_pkg::SrcDeriv;
          cmd_q.b_idx     <= {2'b00, k_q};
          cmd_q.sh        <= fe_grad_pkg::ShNone;
          state_q         <= SMacW;
        end
        SMacW: if (sts_i.mul_done) begin
          cmd_q.wb     <= fe_grad_pkg::WbJacAcc;
          cmd_q.wb_idx <= fe_grad_pkg::idx9(r_q, k_q);
          if (k_q != nl) begin
            k_q     <= k_q + 2'd1;
            state_q <= SMac;
          end else if (r_q != nl) begin
            k_q     <= '0;
            r_q     <= r_q + 2'd1;
            state_q <= SMac;
          end else begin
            k_q     <= '0;
            r_q     <= '0;
            state_q <= sts_i.last ? SCofStart : SIdle;
          end
        end
        SCofStart: begin
          if (sts_i.dim2) begin
            cmd_q.cof2d <= 1'b1;
            state_q     <= SDetInit;
          end else begin
            state_q <= SCofM1;
          end
        end
        SCofM1: begin
          cmd_q.mul_start <= 1'b1;
          cmd_q.a_src     <= fe_grad_pkg::SrcJac;
          cmd_q.a_idx     <= fe_grad_pkg::idx9(r1, k1);
          cmd_q.b_src     <= fe_grad_pkg::SrcJac;
          cmd_q.b_idx     <= fe_grad_pkg::idx9(r2, k2);
          cmd_q.sh        <= fe_grad_pkg::Sh2F;
          state_q         <= SCofW1;
        end
        SCofW1: if (sts_i.mul_done) begin
          cmd_q.wb <= fe_grad_pkg::WbTmp;
          state_q  <= SCofM2;
        end
        SCofM2: begin
          cmd_q.mul_start <= 1'b1;
          cmd_q.a_src     <= fe_grad_pkg::SrcJac;
          cmd_q.a_idx     <= fe_grad_pkg::idx9(r1, k2);
          cmd_q.b_src     <= fe_grad_pkg::SrcJac;
          cmd_q.b_idx     <= fe_grad_pkg::idx9(r2, k1);
          cmd_q.sh        <= fe_grad_pkg::Sh2F;
          state_q         <= SCofW2;
        end
        SCofW2: if (sts_i.mul_done) begin
          cmd_q.wb     <= fe_grad_pkg::WbCof;
          cmd_q.wb_idx <= fe_grad_pkg::idx9(r_q, k_q);
          if (k_q != 2'd2) begin
            k_q     <= k_q + 2'd1;
            state_q <= SCofM1;
          end else if (r_q != 2'd2) begin
            k_q     <= '0;
            r_q     <= r_q + 2'd1;
            state_q <= SCofM1;
          end else begin
            k_q     <= '0;
            r_q     <= '0;
            state_q <= SDetInit;
          end
        end
        SDetInit: begin
          cmd_q.clr_det <= 1'b1;
          r_q           <= '0;
          state_q       <= SDetM;
        end
        SDetM: begin
          cmd_q.mul_start <= 1'b1;
          cmd_q.a_src     <= fe_grad_pkg::SrcJac;
          cmd_q.a_idx     <= fe_grad_pkg::idx9(r_q, 2'd0);
          cmd_q.b_src     <= fe_grad_pkg::SrcCof;
          cmd_q.b_idx     <= fe_grad_pkg::idx9(r_q, 2'd0);
          cmd_q.sh        <= fe_grad_pkg::Sh2F;
          state_q         <= SDetW;
        end
        SDetW: if (sts_i.mul_done) begin
          cmd_q.wb <= fe_grad_pkg::WbDet;
          if (r_q != nl) begin
            r_q     <= r_q + 2'd1;
            state_q <= SDetM;
          end else begin
            r_q     <= '0;
            state_q <= SDetSettle;
          end
        end
        SDetSettle: state_q <= SDetChk;
        SDetChk: begin
          if (sts_i.det_bad) begin
            state_q <= SFinish;
          end else begin
            cmd_q.div_start <= 1'b1;
            state_q         <= SDivW;
          end
        end
        SDivW: if (sts_i.div_done) state_q <= SFinish;
        SFinish: begin
          cmd_q.finish <= 1'b1;
          kind_q       <= fe_grad_pkg::KindDet;
          state_q      <= SEmit;
        end
        SEmit: if (sts_i.out_free) begin
          cmd_q.emit      <= 1'b1;
          cmd_q.emit_kind <= kind_q;
          state_q         <= SIdle;
        end
        SFldRow: begin
          cmd_q.clr_sum <= 1'b1;
          k_q           <= '0;
          state_q       <= SFldM;
        end
        SFldM: begin
          cmd_q.mul_start <= 1'b1;
          cmd_q.a_src     <= fe_grad_pkg::SrcDeriv;
          cmd_q.a_idx     <= {2'b00, k_q};
          cmd_q.b_src     <= fe_grad_pkg::SrcCof;
          cmd_q.b_idx     <= fe_grad_pkg::idx9(r_q, k_q);
          cmd_q.sh        <= fe_grad_pkg::ShF;
          state_q         <= SFldW;
        end
        SFldW: if (sts_i.mul_done) begin
          cmd_q.wb <= fe_grad_pkg::WbSum;
          if (k_q != nl) begin
            k_q     <= k_q + 2'd1;
            state_q <= SFldM;
          end else begin
            k_q     <= '0;
            state_q <= SFldG;
          end
        end
        SFldG: begin
          cmd_q.mul_start <= 1'b1;
          cmd_q.a_src     <= fe_grad_pkg::SrcSum;
          cmd_q.b_src     <= fe_grad_pkg::SrcRecip;
          cmd_q.sh        <= fe_grad_pkg::Sh3F;
          state_q         <= SFldGW;
        end
        SFldGW: if (sts_i.mul_done) begin
          cmd_q.wb     <= fe_grad_pkg::WbGrad;
          cmd_q.wb_idx <= {2'b00, r_q};
          if (r_q != nl) begin
            r_q     <= r_q + 2'd1;
            state_q <= SFldRow;
          end else begin
            r_q     <= '0;
            kind_q  <= fe_grad_pkg::KindGrad;
            state_q <= SEmit;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign in_ready_o = (state_q == SIdle);
  assign cmd_o      = cmd_q;

endmodule

### hdl/fe_gradient_operator.sv
// Isoparametric Jacobian and gradient operator for one element at a time.
// Words arrive on in_i: geometry node words (func 0) accumulate the 2x2 or
// 3x3 Jacobian; the geometry word marked last_node forms the cofactors, the
// determinant and its reciprocal, and returns one determinant word on out_o.
// Each following field word (func 1) returns one gradient word. The register
// written through cfg_we_i and cfg_wdata_i selects two or three dimensions.
// One word is processed at a time; all products go through a single shared
// multiplier. A geometry word costs D*D products; the last one adds 18
// cofactor products in 3D, D determinant products and the bit-serial
// reciprocal divider, which runs only for a positive determinant. A field
// word costs D*(D+1) products. The next input word is taken as soon as the
// previous one has finished its products or, if it has a result, has handed
// that result to the output register, even while that result is still
// waiting for out_o.ready. A stalled receiver holds the block only once a
// new result needs the output register. Reset clears the Jacobian sums,
// cofactors, reciprocal and flags and selects three dimensions.
module fe_gradient_operator #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_wdata_i,
  fe_grad_in_if.sink     in_i,
  fe_grad_out_if.source  out_o
);

  fe_grad_pkg::cmd_t cmd;
  fe_grad_pkg::sts_t sts;
  logic              in_ready;

  fe_grad_dp #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_wdata_i,
    .in_ready_i(in_ready),
    .cmd_i(cmd),
    .sts_o(sts),
    .in_i(in_i),
    .out_o(out_o)
  );

  fe_grad_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .sts_i(sts),
    .in_ready_o(in_ready),
    .cmd_o(cmd)
  );

  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_start |-> !sts.mul_busy)
    else $error("multiplier started while busy");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result written over a pending output word");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (!sts.mul_busy && !sts.div_busy))
    else $error("input word taken while arithmetic is in progress");

endmodule
